// File: rtl/core/sine_tone_generator_assert.svh
// ----------------------------------------------------------------------------
// sine tone generator assertion macros
// shorthand for clocked assertions with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define STG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stg assertion failed");

// next-cycle implication
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stg assertion failed");

`endif

// File: rtl/core/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// shared types, constants and the quarter-wave table builder
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

	localparam int unsigned PHASE_BITS_DEF      = 32;
	localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
	localparam int unsigned MAX_CHANNELS        = 8;
	localparam int unsigned QUEUE_DEPTH         = 4;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned CHAN_W      = 3;
	localparam int unsigned NCH_W       = 4;
	localparam int unsigned VOL_W       = 17;
	localparam int unsigned MAG_W       = 31;

	localparam logic [30:0] FS_NARROW   = 31'd32767;
	localparam logic [30:0] FS_WIDE     = 31'd2147483647;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_STEP    = 8'd0,
		REG_VOLUME        = 8'd1,
		REG_CHANNEL_COUNT = 8'd2,
		REG_WIDE_FORMAT   = 8'd3
	} stg_reg_t;

	typedef struct packed {
		logic [31:0]      phase_step;
		logic [VOL_W-1:0] volume;
		logic [NCH_W-1:0] channel_count;
		logic             wide_format;
	} stg_cfg_t;

	// per-frame control carried beside the table address
	typedef struct packed {
		logic neg;
		logic last;
	} stg_ctl_t;

	// quarter-wave entry k in q1.30, eight-term taylor series, clamped to [0, 1]
	function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned abits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [64:0] sum;
		int unsigned        n;
		x    = (64'(HALF_PI_Q30) * 64'(k)) >> abits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed({1'b0, x});
		for (n = 1; n <= 7; n++) begin
			// divisor of the taylor term, (2n)(2n+1)
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0) begin
				sum = sum - $signed({1'b0, term});
			end else begin
				sum = sum + $signed({1'b0, term});
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed({34'd0, ONE_Q30})) begin
			sum = $signed({34'd0, ONE_Q30});
		end
		return sum[30:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/stg_queue.sv
// ----------------------------------------------------------------------------
// stg_queue
// small first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module stg_queue #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stg_front.sv
// ----------------------------------------------------------------------------
// stg_front
// phase accumulator and quarter-wave address classification
// ----------------------------------------------------------------------------
`default_nettype none

module stg_front #(
	parameter int unsigned PHASE_BITS      = 32,
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire stg_pkg::stg_cfg_t        cfg,
	input  wire logic                     accept,
	input  wire logic                     last_in_block,
	output logic [TABLE_ADDR_BITS:0]      addr,
	output stg_pkg::stg_ctl_t             ctl
);

	import stg_pkg::*;

	localparam int unsigned IDX_W = TABLE_ADDR_BITS + 2;

	logic [PHASE_BITS-1:0]      phase_q;
	logic [PHASE_BITS-1:0]      phase_next;
	logic [IDX_W-1:0]           idx;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS:0]   a_ext;

	// wraps modulo one turn by width
	assign phase_next = phase_q + PHASE_BITS'(cfg.phase_step);
	assign idx        = phase_next[PHASE_BITS-1 -: IDX_W];
	assign quad       = idx[IDX_W-1 -: 2];
	assign a_ext      = {1'b0, idx[TABLE_ADDR_BITS-1:0]};

	// odd quadrants read the table mirrored
	assign addr     = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - a_ext) : a_ext;
	assign ctl.neg  = quad[1];
	assign ctl.last = last_in_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stg_back.sv
// ----------------------------------------------------------------------------
// stg_back
// table read, volume and full-scale scaling, per-channel copies
// ----------------------------------------------------------------------------
`default_nettype none

module stg_back #(
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire stg_pkg::stg_cfg_t      cfg,
	input  wire logic                   q_empty,
	input  wire logic [TABLE_ADDR_BITS:0] q_addr,
	input  wire stg_pkg::stg_ctl_t      q_ctl,
	output logic                        q_pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [stg_pkg::SAMPLE_W-1:0] out_sample,
	output logic [stg_pkg::CHAN_W-1:0]  out_channel,
	output logic                        out_last,
	output logic                        out_block_end
);

	import stg_pkg::*;

	localparam int unsigned TAB_LEN = (1 << TABLE_ADDR_BITS) + 1;

	logic [MAG_W-1:0] rom_w [TAB_LEN];

	genvar k;
	generate
		for (k = 0; k < TAB_LEN; k++) begin : g_rom
			assign rom_w[k] = sine_entry(k, TABLE_ADDR_BITS);
		end
	endgenerate

	logic                 v_s1, v_s2, v_s3;
	stg_ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [MAG_W-1:0]     m_s1;
	logic [31:0]          g_s2;
	logic [SAMPLE_W-1:0]  sample_s3;
	logic                 adv;
	logic                 load;

	logic [47:0]          prod1;
	logic [62:0]          prod2;
	logic [30:0]          fs;
	logic [32:0]          mag_full;
	logic [30:0]          mag;

	logic [NCH_W-1:0]     nch;
	logic [NCH_W-1:0]     ch_q;
	logic [NCH_W-1:0]     ch_next;
	logic                 valid_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic                 last_q;
	logic                 bend_q;
	logic                 blk_q;

	// channel count folded into one to the channel limit
	always_comb begin
		priority if (cfg.channel_count == '0) begin
			nch = NCH_W'(1);
		end else if (cfg.channel_count > NCH_W'(MAX_CHANNELS)) begin
			nch = NCH_W'(MAX_CHANNELS);
		end else begin
			nch = cfg.channel_count;
		end
	end

	assign load  = v_s3 && (!valid_q || (out_ready && last_q));
	assign adv   = !v_s3 || load;
	assign q_pop = adv && !q_empty;

	assign fs       = cfg.wide_format ? FS_WIDE : FS_NARROW;
	assign prod1    = 48'(m_s1) * 48'(cfg.volume);
	assign prod2    = 63'(g_s2) * 63'(fs);
	assign mag_full = prod2[62:30];
	assign mag      = (mag_full > 33'(fs)) ? fs : mag_full[30:0];
	assign ch_next  = ch_q + NCH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= !q_empty;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (valid_q && out_ready && last_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1      <= rom_w[q_addr];
			ctl_s1    <= q_ctl;
			g_s2      <= prod1[47:16];
			ctl_s2    <= ctl_s1;
			sample_s3 <= ctl_s2.neg ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);
			ctl_s3    <= ctl_s2;
		end
		if (load) begin
			sample_q <= sample_s3;
			ch_q     <= '0;
			last_q   <= (nch == NCH_W'(1));
			bend_q   <= (nch == NCH_W'(1)) && ctl_s3.last;
			blk_q    <= ctl_s3.last;
		end else if (valid_q && out_ready && !last_q) begin
			ch_q   <= ch_next;
			last_q <= (ch_next + NCH_W'(1) == nch);
			bend_q <= (ch_next + NCH_W'(1) == nch) && blk_q;
		end
	end

	assign out_valid     = valid_q;
	assign out_sample    = sample_q;
	assign out_channel   = ch_q[CHAN_W-1:0];
	assign out_last      = last_q;
	assign out_block_end = bend_q;

endmodule

`default_nettype wire

// File: rtl/core/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator
// direct digital synthesis sine oscillator with per-channel copies
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries one item per audio frame; tdata bit 0 marks the final
//    frame of a render request
//  - m_axis gives one item per channel, channel 0 first; tlast marks the
//    last channel of the frame, tuser holds channel index and block end
//  - cfg writes registers: 0 phase step, 1 volume, 2 channel count,
//    3 wide format; other indexes are ignored; write only while idle
//  - path: a taken item passes the queue, the table read, volume and
//    full-scale stages and the output register to give its first copy
//  - throughput: a frame takes one copy per effective channel (a count of
//    zero acts as one, above eight as eight), limited by the single
//    output register sending one copy per cycle while the receiver is ready
//  - behind a stalled output the four-deep queue and the three pipeline
//    stages hold up to seven more frames; once the queue is full,
//    s_axis_tready drops
//  - when the receiver stalls, the held item stays unchanged on m_axis
//  - reset: phase zero, step 0, volume full scale, two channels, 16-bit
//    format; the sine table is constant so no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator #(
	parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
	parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input frame requests
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [0] last_in_block
	// output samples
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [31:0] sample
	output logic [3:0]                         m_axis_tuser,  // [2:0] channel_index, [3] block_end
	output logic                               m_axis_tlast,  // last_channel
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [stg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [stg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import stg_pkg::*;

	localparam int unsigned Q_W = TABLE_ADDR_BITS + 1 + $bits(stg_ctl_t);

	stg_cfg_t                 cfg_q;
	logic                     accept;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic [TABLE_ADDR_BITS:0] f_addr;
	stg_ctl_t                 f_ctl;
	logic [Q_W-1:0]           q_out;
	logic [TABLE_ADDR_BITS:0] b_addr;
	stg_ctl_t                 b_ctl;
	logic [CHAN_W-1:0]        b_channel;
	logic                     b_block_end;

	// register file, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step    <= '0;
			cfg_q.volume        <= VOL_W'(65536);
			cfg_q.channel_count <= NCH_W'(2);
			cfg_q.wide_format   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PHASE_STEP: begin
					cfg_q.phase_step <= cfg_data;
				end
				REG_VOLUME: begin
					cfg_q.volume <= cfg_data[VOL_W-1:0];
				end
				REG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= cfg_data[NCH_W-1:0];
				end
				REG_WIDE_FORMAT: begin
					cfg_q.wide_format <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// front takes an item whenever the queue has room
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;

	stg_front #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accept        (accept),
		.last_in_block (s_axis_tdata[0]),
		.addr          (f_addr),
		.ctl           (f_ctl)
	);

	stg_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({f_addr, f_ctl}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign b_addr = q_out[Q_W-1 -: TABLE_ADDR_BITS + 1];
	assign b_ctl  = q_out[$bits(stg_ctl_t)-1:0];

	stg_back #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_addr        (b_addr),
		.q_ctl         (b_ctl),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_sample    (m_axis_tdata),
		.out_channel   (b_channel),
		.out_last      (m_axis_tlast),
		.out_block_end (b_block_end)
	);

	assign m_axis_tuser = {b_block_end, b_channel};

endmodule

`default_nettype wire

// File: rtl/core/stg_checker.sv
// ----------------------------------------------------------------------------
// stg_checker
// port-level checks on the sample stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sine_tone_generator_assert.svh"

module stg_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [3:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic out_hs;

	assign out_hs = m_axis_tvalid && m_axis_tready;

	// a stalled item holds
	`STG_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// block end only on the last channel
	`STG_ASSERT_IMP(a_bend_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[3], m_axis_tlast)

	// copies of a frame follow at once with the same sample and the next channel
	`STG_ASSERT_NEXT(a_next_copy, clk, arst_n, out_hs && !m_axis_tlast, m_axis_tvalid && m_axis_tdata == $past(m_axis_tdata) && m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1)

	// a new frame starts on channel zero
	`STG_ASSERT_NEXT(a_frame_start, clk, arst_n, out_hs && m_axis_tlast, !m_axis_tvalid || m_axis_tuser[2:0] == 3'd0)

endmodule

bind sine_tone_generator stg_port_checker u_stg_port_checker (.*);

`default_nettype wire

// File: bench/stg_checker.sv
// ----------------------------------------------------------------------------
// stg_checker
// watches the register, frame and sample channels, predicts every sample
// copy from its own oscillator model and compares all its fields
// ----------------------------------------------------------------------------
module stg_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] last_in_block
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // [31:0] sample
	input  wire logic [3:0]  m_tuser,   // [2:0] channel_index, [3] block_end
	input  wire logic        m_tlast,   // last_channel
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               mismatches,
	output int               outstanding,
	output int               frames_taken,
	output int               copies_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import stg_pkg::*;

	localparam int TW     = TABLE_ADDR_BITS_DEF;
	localparam int QW_TOP = 1 << TW;

	typedef struct packed {
		logic [31:0] sample;
		logic [2:0]  chan;
		logic        last_chan;
		logic        blk_end;
	} copy_t;

	logic [30:0] quarter_wave [0:QW_TOP];
	copy_t       copies_due [$];

	logic [31:0] osc_phase;
	logic [31:0] step_reg;
	logic [16:0] gain_reg;
	logic [3:0]  chans_reg;
	logic        wide_reg;

	int fails;
	int frames;
	int checked;

	// quarter-wave sine in q1.30 by a truncating eight-term series
	function automatic logic [30:0] taylor_sine(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x_sq;
		logic [63:0] term;
		longint      acc;
		x    = (64'(HALF_PI_Q30) * 64'(k)) >> TW;
		x_sq = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(ONE_Q30)) begin
			acc = longint'(ONE_Q30);
		end
		return acc[30:0];
	endfunction

	initial begin
		for (int k = 0; k <= QW_TOP; k++) begin
			quarter_wave[k] = taylor_sine(k);
		end
	end

	task automatic apply_write(input logic [7:0] idx, input logic [31:0] val);
		case (idx)
			REG_PHASE_STEP: begin
				step_reg = val;
			end
			REG_VOLUME: begin
				gain_reg = val[16:0];
			end
			REG_CHANNEL_COUNT: begin
				chans_reg = val[3:0];
			end
			REG_WIDE_FORMAT: begin
				wide_reg = val[0];
			end
			default: begin
			end
		endcase
	endtask

	// advance the phase and queue one copy per channel
	task automatic predict_frame(input logic blk_last);
		logic [TW+1:0] idx;
		logic [1:0]    quad;
		logic [TW:0]   addr;
		logic [63:0]   fs;
		logic [63:0]   g;
		logic [63:0]   mag;
		logic [31:0]   smp;
		int            nch;
		copy_t         cp;
		osc_phase = osc_phase + step_reg;
		idx  = osc_phase[31 -: TW+2];
		quad = idx[TW+1:TW];
		addr = {1'b0, idx[TW-1:0]};
		if (quad[0]) begin
			addr = (TW+1)'(QW_TOP) - addr;
		end
		fs  = wide_reg ? 64'(FS_WIDE) : 64'(FS_NARROW);
		g   = (64'(quarter_wave[addr]) * 64'(gain_reg)) >> 16;
		mag = (g * fs) >> 30;
		if (mag > fs) begin
			mag = fs;
		end
		smp = quad[1] ? 32'd0 - mag[31:0] : mag[31:0];
		nch = int'(chans_reg);
		if (nch == 0) begin
			nch = 1;
		end
		if (nch > MAX_CHANNELS) begin
			nch = MAX_CHANNELS;
		end
		for (int c = 0; c < nch; c++) begin
			cp.sample    = smp;
			cp.chan      = c[2:0];
			cp.last_chan = (c == nch - 1);
			cp.blk_end   = (c == nch - 1) && blk_last;
			copies_due.push_back(cp);
		end
		frames++;
	endtask

	task automatic check_copy();
		copy_t want;
		copy_t got;
		got = {m_tdata, m_tuser[2:0], m_tlast, m_tuser[3]};
		if (copies_due.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("%0t: unexpected sample %h chan %0d last %b end %b", $realtime,
					got.sample, got.chan, got.last_chan, got.blk_end);
			end
		end else begin
			want = copies_due.pop_front();
			checked++;
			if (got !== want) begin
				fails++;
				if (fails <= 10) begin
					$display("%0t: sample mismatch, want %h/%0d/%b/%b got %h/%0d/%b/%b",
						$realtime, want.sample, want.chan, want.last_chan, want.blk_end,
						got.sample, got.chan, got.last_chan, got.blk_end);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_phase = '0;
			step_reg  = '0;
			gain_reg  = 17'd65536;
			chans_reg = 4'd2;
			wide_reg  = 1'b0;
			copies_due.delete();
			fails   = 0;
			frames  = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			if (s_tvalid && s_tready) begin
				predict_frame(s_tdata[0]);
			end
			if (m_tvalid && m_tready) begin
				check_copy();
			end
		end
		mismatches     <= fails;
		outstanding    <= copies_due.size();
		frames_taken   <= frames;
		copies_checked <= checked;
	end

endmodule

// File: bench/tb_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// tb_sine_tone_generator
// drives frame requests and register writes into the tone generator under
// several stall patterns and lets stg_checker predict and compare the output
// ----------------------------------------------------------------------------
module tb_sine_tone_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import stg_pkg::*;

	// register indexes that decode to nothing
	localparam logic [7:0] CFG_SPARE_IDX = 8'd4;
	localparam logic [7:0] CFG_LAST_IDX  = 8'hFF;

	localparam int HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int ROUND_ITEMS = 25;      // frames per random setting
	localparam int CYCLE_LIMIT = 400000;  // watchdog
	localparam int SETTLE      = 10;      // a little over the pipeline latency

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [0] last_in_block
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] sample
	logic [3:0]  m_axis_tuser;        // [2:0] channel_index, [3] block_end
	logic        m_axis_tlast;        // last_channel
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index     = '0;
	logic [31:0] cfg_data      = '0;

	int mismatches;
	int outstanding;
	int frames_taken;
	int copies_checked;

	int tx_idle_pct  = 0;   // chance per cycle that the sender idles
	int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
	bit hold_request = 1'b0;
	int settings_used = 0;
	int cycles = 0;

	sine_tone_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// the checker sees exactly what the block sees and hands back its tallies
	stg_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tuser        (m_axis_tuser),
		.m_tlast        (m_axis_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.frames_taken   (frames_taken),
		.copies_checked (copies_checked)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// watchdog: a hung handshake or a lost sample ends here
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_sine_tone_generator: done, errors");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off when asked for
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// one register write; cfg_valid is left high for a following write
	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] step, input logic [31:0] vol,
			input logic [31:0] nch, input logic [31:0] wide);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_VOLUME, vol);
		write_reg(REG_CHANNEL_COUNT, nch);
		write_reg(REG_WIDE_FORMAT, wide);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// random setting: mostly sane values, sometimes raw 32-bit data so the
	// masked-off bits, the gain above full scale and odd channel counts appear
	task automatic shuffle_settings();
		logic [31:0] step;
		logic [31:0] vol;
		logic [31:0] nch;
		step = ($urandom_range(1) == 1) ? $urandom : $urandom_range(1 << 24);
		vol  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536);
		nch  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8, 1);
		apply_settings(step, vol, nch, $urandom);
	endtask

	// offer one frame request, idling first at the sender's rate;
	// tvalid stays high on return so back-to-back items run without a gap
	task automatic send_frame(input logic blk_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, blk_last};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_frame($urandom_range(3) == 0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// every frame yields at least one copy, so an empty store means the
	// block has gone quiet; the extra cycles cover the pipeline depth
	task automatic drain();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// reset setting: zero step keeps the phase at zero, two channels
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b0);
		s_axis_tvalid <= 1'b0;
		drain();

		// writes to undecoded indexes must leave every register alone
		write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
		write_reg(CFG_LAST_IDX, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_frame(1'b1);
		s_axis_tvalid <= 1'b0;
		drain();

		// quarter-turn step: every quadrant boundary, the mirrored top
		// address and both narrow peaks, single channel
		apply_settings(32'h4000_0000, 32'd65536, 32'd1, 32'd0);
		repeat (5) send_frame(1'b0);
		s_axis_tvalid <= 1'b0;
		drain();

		// gain above full scale saturates in wide format; junk above the
		// register widths, channel count of zero gives one channel
		apply_settings(32'h4008_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b0);
		s_axis_tvalid <= 1'b0;
		drain();

		// largest step wraps the phase, zero gain, count above eight clamps
		apply_settings(32'hFFFF_FFFF, 32'd0, 32'd15, 32'd1);
		send_frame(1'b0);
		send_frame(1'b1);
		s_axis_tvalid <= 1'b0;
		drain();

		// one table address per frame near zero, full gain, eight channels
		apply_settings(32'h0010_0000, 32'd65536, 32'd8, 32'd1);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b1);
		s_axis_tvalid <= 1'b0;
		drain();

		// ---- random part, one idling pattern per phase ----
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 76;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 76;
				end
				default: begin
					tx_idle_pct  = 9;
					rx_stall_pct = 9;
				end
			endcase
			for (int r = 0; r < 3; r++) begin
				shuffle_settings();
				send_random(ROUND_ITEMS);
				drain();
			end
		end

		// ---- back-pressure: receiver holds off while frames keep coming,
		// so the frame queue fills and the input stalls ----
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		shuffle_settings();
		hold_request = 1'b1;
		send_random(30);
		drain();

		$display("%0d frame requests over %0d register settings, %0d sample copies checked",
			frames_taken, settings_used, copies_checked);
		$display("covered quadrant edges, gain saturation, channel clamps and long stalls");
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_sine_tone_generator: done, clean");
		end else begin
			$display("tb_sine_tone_generator: done, errors");
		end
		$finish;
	end

endmodule
